[rtl/core/iocw_pkg.sv]
// ----------------------------------------------------------------------------
// iocw_pkg: shared types and constants for the completion watermark unit
// Window size, command and result words, cell control and sequencer states.
// ----------------------------------------------------------------------------
package iocw_pkg;

  // Depth of the early-completion bitmap, one cell per serial above watermark
  localparam int WINDOW = 64;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SER_W  = 64;

  // Command codes
  localparam logic FUNC_ONE     = 1'b0;
  localparam logic FUNC_THROUGH = 1'b1;

  typedef struct packed {
    logic             func;
    logic [SER_W-1:0] serial;
  } in_t;

  typedef struct packed {
    logic [SER_W-1:0] watermark;
    logic             held_early;
    logic             dropped;
  } out_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic clear;
    logic shift;
  } slot_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JUMP,
    ST_ABSORB,
    ST_CHASE,
    ST_REPORT
  } state_t;

endpackage

[rtl/core/in_order_completion_watermark_unit.sv]
// ----------------------------------------------------------------------------
// in_order_completion_watermark_unit: completion watermark with reorder row
// Ignore, hold, drop and wide jumps go from idle straight to report; a jump
// by d < WINDOW first shifts the row d cells down in the jump state, an
// advance passes absorb and then chases one early serial per cycle. busy is
// high after acceptance through the done cycle; start is taken only in idle.
// rst (synchronous) clears the watermark to zero and empties the row.
// ----------------------------------------------------------------------------
module in_order_completion_watermark_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  iocw_pkg::in_t  cmd,
  output logic           done,
  output iocw_pkg::out_t res
);

  iocw_pkg::state_t             state, state_next;
  logic [iocw_pkg::SER_W-1:0]   wm, wm_next;
  logic                         held, held_next;
  logic                         drop, drop_next;
  logic [iocw_pkg::IDX_W-1:0]   cnt, cnt_next;

  iocw_pkg::slot_ctl_t          ctl;
  logic [iocw_pkg::WINDOW-1:0]  set_sel;
  logic                         head;

  logic [iocw_pkg::SER_W-1:0]   gap;
  logic [iocw_pkg::IDX_W-1:0]   gap_m1;
  logic                         above;
  logic                         in_win;
  logic                         wide_jump;

  // distance of the incoming serial above the watermark
  assign above     = cmd.serial > wm;
  assign gap       = cmd.serial - wm;
  assign gap_m1    = iocw_pkg::IDX_W'(gap - 64'd1);
  assign in_win    = gap <= 64'(iocw_pkg::WINDOW);
  assign wide_jump = gap >= 64'(iocw_pkg::WINDOW);

  iocw_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .set_sel (set_sel),
    .head    (head)
  );

  // sequencer: next state, watermark and row control
  always_comb begin
    state_next = state;
    wm_next    = wm;
    held_next  = held;
    drop_next  = drop;
    cnt_next   = cnt;
    ctl        = '0;
    set_sel    = '0;
    case (state)
      iocw_pkg::ST_IDLE: begin
        if (start) begin
          held_next  = 1'b0;
          drop_next  = 1'b0;
          state_next = iocw_pkg::ST_REPORT;
          if (above) begin
            if (cmd.func == iocw_pkg::FUNC_THROUGH) begin
              wm_next = cmd.serial;
              if (wide_jump) begin
                ctl.clear = 1'b1;
              end else begin
                cnt_next   = gap[iocw_pkg::IDX_W-1:0];
                state_next = iocw_pkg::ST_JUMP;
              end
            end else if (gap == 64'd1) begin
              wm_next    = cmd.serial;
              state_next = iocw_pkg::ST_ABSORB;
            end else if (in_win) begin
              set_sel[gap_m1] = 1'b1;
              held_next       = 1'b1;
            end else begin
              drop_next = 1'b1;
            end
          end
        end
      end
      // discard held serials one cell per cycle
      iocw_pkg::ST_JUMP: begin
        ctl.shift = 1'b1;
        cnt_next  = cnt - 1'b1;
        if (cnt == iocw_pkg::IDX_W'(1)) begin
          state_next = iocw_pkg::ST_REPORT;
        end
      end
      // the new watermark's own cell leaves the row
      iocw_pkg::ST_ABSORB: begin
        ctl.shift  = 1'b1;
        state_next = iocw_pkg::ST_CHASE;
      end
      // soak up consecutive early serials
      iocw_pkg::ST_CHASE: begin
        if (head) begin
          ctl.shift = 1'b1;
          wm_next   = wm + 64'd1;
        end else begin
          state_next = iocw_pkg::ST_REPORT;
        end
      end
      iocw_pkg::ST_REPORT: begin
        state_next = iocw_pkg::ST_IDLE;
      end
      default: begin
        state_next = iocw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iocw_pkg::ST_IDLE;
      wm    <= '0;
      held  <= 1'b0;
      drop  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      wm    <= wm_next;
      held  <= held_next;
      drop  <= drop_next;
      cnt   <= cnt_next;
    end
  end

  // result word shown for the single report cycle
  assign busy           = state != iocw_pkg::ST_IDLE;
  assign done           = state == iocw_pkg::ST_REPORT;
  assign res.watermark  = wm;
  assign res.held_early = held;
  assign res.dropped    = drop;

endmodule

[rtl/core/iocw_slot.sv]
// ----------------------------------------------------------------------------
// iocw_slot: one cell of the early-completion row
// Holds one early bit; clears, loads from its upper neighbour or sets.
// ----------------------------------------------------------------------------
module iocw_slot (
  input  logic                clk,
  input  logic                rst,
  input  iocw_pkg::slot_ctl_t ctl,
  input  logic                set_bit,
  input  logic                from_up,
  output logic                bit_q
);

  logic bit_next;

  // clear wins, then shift toward the watermark, then a new early serial
  always_comb begin
    bit_next = bit_q;
    if (ctl.clear) begin
      bit_next = 1'b0;
    end else if (ctl.shift) begin
      bit_next = from_up;
    end else if (set_bit) begin
      bit_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_next;
    end
  end

endmodule

[rtl/core/iocw_chain.sv]
// ----------------------------------------------------------------------------
// iocw_chain: row of early-bit cells
// Cell k holds serial watermark+1+k; a shift moves every bit one cell down.
// ----------------------------------------------------------------------------
module iocw_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  iocw_pkg::slot_ctl_t         ctl,
  input  logic [iocw_pkg::WINDOW-1:0] set_sel,
  output logic                        head
);

  logic [iocw_pkg::WINDOW-1:0] bits;
  logic [iocw_pkg::WINDOW:0]   feed;

  // top cell is fed zero; each other cell is fed by the one above it
  assign feed[iocw_pkg::WINDOW] = 1'b0;

  for (genvar k = 0; k < iocw_pkg::WINDOW; k++) begin : g_row
    iocw_slot u_slot (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .set_bit (set_sel[k]),
      .from_up (feed[k+1]),
      .bit_q   (bits[k])
    );
    assign feed[k] = bits[k];
  end

  assign head = feed[0];

endmodule
